### src/tcf_pkg.sv
package tcf_pkg;

  localparam int DEPTH    = 16;
  localparam int TAG_BITS = 16;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef logic [1:0]       mode_t;
  typedef logic [1:0]       status_t;
  typedef logic [15:0]      tag_t;
  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam tag_t TAG_MASK = 16'((64'd1 << TAG_BITS) - 64'd1);

  localparam mode_t MODE_ENQ = 2'd0;
  localparam mode_t MODE_ANY = 2'd1;
  localparam mode_t MODE_CLS = 2'd2;

  localparam status_t ST_ENQ  = 2'd0;
  localparam status_t ST_DEQ  = 2'd1;
  localparam status_t ST_NONE = 2'd2;
  localparam status_t ST_FULL = 2'd3;

  localparam logic KIND_CAT = 1'b0;
  localparam logic KIND_DOG = 1'b1;

endpackage

### src/tcf_req_if.sv
interface tcf_req_if;
  logic            valid;
  logic            ready;
  tcf_pkg::mode_t  mode;
  logic            kind;
  tcf_pkg::tag_t   tag;

  modport source(output valid, mode, kind, tag, input ready);
  modport sink(input valid, mode, kind, tag, output ready);
endinterface

### src/tcf_rsp_if.sv
interface tcf_rsp_if;
  logic             valid;
  logic             ready;
  tcf_pkg::status_t status;
  logic             out_kind;
  tcf_pkg::tag_t    out_tag;

  modport source(output valid, status, out_kind, out_tag, input ready);
  modport sink(input valid, status, out_kind, out_tag, output ready);
endinterface

### src/two_class_fifo_typed_dequeue_core.sv
// two-class queue with typed dequeue
// req channel carries mode, kind and tag: enqueue at the tail, dequeue the
// oldest item of any class, or dequeue the oldest item of the class in kind.
// rsp channel returns one item per request: status, out_kind and out_tag.
// each class lives in its own one-port synchronous memory; a register of
// kind bits, oldest first, tells dequeue-any which head is older and closes
// its gap when an item leaves.
// an accepted request is executed in the busy state that follows: the head
// read of the class memories feeds the compare and pointer update, and the
// response is registered.
// a request is taken only when the core is not busy and the response
// register is free or being drained at the same edge; a stalled receiver
// holds the response and blocks further requests until it is taken.
// reset (rst, synchronous) empties the queue at once: counts and pointers
// clear, the memory contents are left as they are.
module two_class_fifo_typed_dequeue_core (
  input  logic       clk,
  input  logic       rst,
  tcf_req_if.sink    req,
  tcf_rsp_if.source  rsp
);

  tcf_pkg::tag_t cat_mem [tcf_pkg::DEPTH];
  tcf_pkg::tag_t dog_mem [tcf_pkg::DEPTH];

  tcf_pkg::tag_t cat_rd;
  tcf_pkg::tag_t dog_rd;

  logic             busy;
  tcf_pkg::mode_t   op_mode;
  logic             op_kind;
  tcf_pkg::tag_t    op_tag;

  tcf_pkg::ptr_t cat_head, cat_tail, dog_head, dog_tail;
  tcf_pkg::cnt_t cat_cnt, dog_cnt, occupancy;

  logic [tcf_pkg::DEPTH-1:0] order;
  logic [tcf_pkg::DEPTH-1:0] order_next;
  logic                      drop;

  logic             accept;
  logic             cat_avail, dog_avail, cat_older;
  logic             take_cat, take_dog, do_enq;
  tcf_pkg::status_t status_next;
  logic             kind_next;
  tcf_pkg::tag_t    tag_next;

  function automatic tcf_pkg::ptr_t ptr_inc(tcf_pkg::ptr_t p);
    if (p == tcf_pkg::PTR_W'(tcf_pkg::DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign req.ready = !busy && (!rsp.valid || rsp.ready);
  assign accept    = req.valid && req.ready;

  assign cat_avail = (cat_cnt != '0);
  assign dog_avail = (dog_cnt != '0);
  assign cat_older = cat_avail && (!dog_avail || order[0] == tcf_pkg::KIND_CAT);

  // from the removed position on, every kind bit moves one place forward
  always_comb begin
    drop       = (op_mode == tcf_pkg::MODE_ANY);
    order_next = order;
    for (int i = 0; i < tcf_pkg::DEPTH - 1; i++) begin
      if ((tcf_pkg::CNT_W'(i) < occupancy) && (order[i] == op_kind)) begin
        drop = 1'b1;
      end
      if (drop) begin
        order_next[i] = order[i + 1];
      end
    end
  end

  always_comb begin
    take_cat    = 1'b0;
    take_dog    = 1'b0;
    do_enq      = 1'b0;
    status_next = tcf_pkg::ST_NONE;
    unique case (op_mode)
      tcf_pkg::MODE_ENQ: begin
        if (occupancy == tcf_pkg::CNT_W'(tcf_pkg::DEPTH)) begin
          status_next = tcf_pkg::ST_FULL;
        end else begin
          do_enq      = 1'b1;
          status_next = tcf_pkg::ST_ENQ;
        end
      end
      tcf_pkg::MODE_ANY: begin
        take_cat = cat_older;
        take_dog = !cat_older && dog_avail;
      end
      tcf_pkg::MODE_CLS: begin
        take_cat = (op_kind == tcf_pkg::KIND_CAT) && cat_avail;
        take_dog = (op_kind == tcf_pkg::KIND_DOG) && dog_avail;
      end
      default: begin
      end
    endcase
    if (take_cat || take_dog) begin
      status_next = tcf_pkg::ST_DEQ;
    end
    kind_next = take_dog;
    tag_next  = take_cat ? cat_rd : (take_dog ? dog_rd : '0);
  end

  // head reads issued at accept, data ready in the execute cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      cat_rd  <= cat_mem[cat_head];
      dog_rd  <= dog_mem[dog_head];
      op_mode <= req.mode;
      op_kind <= req.kind;
      op_tag  <= req.tag & tcf_pkg::TAG_MASK;
    end
  end

  always_ff @(posedge clk) begin
    if (busy && do_enq) begin
      if (op_kind == tcf_pkg::KIND_DOG) begin
        dog_mem[dog_tail] <= op_tag;
      end else begin
        cat_mem[cat_tail] <= op_tag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      cat_head  <= '0;
      cat_tail  <= '0;
      dog_head  <= '0;
      dog_tail  <= '0;
      cat_cnt   <= '0;
      dog_cnt   <= '0;
      occupancy <= '0;
      order     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      if (accept) begin
        busy <= 1'b1;
      end
      if (busy) begin
        busy         <= 1'b0;
        rsp.valid    <= 1'b1;
        rsp.status   <= status_next;
        rsp.out_kind <= kind_next;
        rsp.out_tag  <= tag_next;
        if (do_enq) begin
          occupancy <= occupancy + 1'b1;
          order[occupancy[tcf_pkg::PTR_W-1:0]] <= op_kind;
          if (op_kind == tcf_pkg::KIND_DOG) begin
            dog_tail <= ptr_inc(dog_tail);
            dog_cnt  <= dog_cnt + 1'b1;
          end else begin
            cat_tail <= ptr_inc(cat_tail);
            cat_cnt  <= cat_cnt + 1'b1;
          end
        end
        if (take_cat || take_dog) begin
          order <= order_next;
        end
        if (take_cat) begin
          cat_head  <= ptr_inc(cat_head);
          cat_cnt   <= cat_cnt - 1'b1;
          occupancy <= occupancy - 1'b1;
        end
        if (take_dog) begin
          dog_head  <= ptr_inc(dog_head);
          dog_cnt   <= dog_cnt - 1'b1;
          occupancy <= occupancy - 1'b1;
        end
      end
    end
  end

endmodule
